// ----- src/swe_pkg.sv -----
// Shared types, constants and sequencer step codes of the stereo width enhancer.
package swe_pkg;

    typedef logic signed [31:0] t_op;
    typedef logic signed [63:0] t_prod;
    typedef logic signed [23:0] t_q420;

    // Sequencer steps, one frame walks ST_WID .. ST_OUT in order
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_WID  = 4'd1;
    localparam logic [3:0] ST_REV  = 4'd2;
    localparam logic [3:0] ST_APF  = 4'd3;
    localparam logic [3:0] ST_DLY  = 4'd4;
    localparam logic [3:0] ST_APS  = 4'd5;
    localparam logic [3:0] ST_SUM  = 4'd6;
    localparam logic [3:0] ST_FB   = 4'd7;
    localparam logic [3:0] ST_MIX  = 4'd8;
    localparam logic [3:0] ST_LR   = 4'd9;
    localparam logic [3:0] ST_RVB  = 4'd10;
    localparam logic [3:0] ST_RVU  = 4'd11;
    localparam logic [3:0] ST_WET  = 4'd12;
    localparam logic [3:0] ST_CLP  = 4'd13;
    localparam logic [3:0] ST_OUT  = 4'd14;

    // Configuration register indexes
    localparam logic [1:0] REG_WIDTH = 2'd0;
    localparam logic [1:0] REG_DEPTH = 2'd1;
    localparam logic [1:0] REG_MONO  = 2'd2;

    localparam logic [15:0] GAIN_MAX    = 16'd32768;
    localparam logic [15:0] WIDTH_RESET = 16'd16384;
    localparam logic [15:0] DEPTH_RESET = 16'd16384;

    // Coefficients with 16 fraction bits; UNITY_Q15 is 1.0 with 15 fraction bits
    localparam t_op C_0P7  = 32'sd45875;
    localparam t_op C_0P3  = 32'sd19661;
    localparam t_op C_0P15 = 32'sd9830;
    localparam t_op UNITY_Q15 = 32'sd32768;

    localparam t_prod Q420_MAX = 64'sd8388607;
    localparam t_prod Q420_MIN = -64'sd8388608;
    localparam t_prod ONE_Q420 = 64'sd1048576;

    typedef struct packed {
        logic [3:0]  step;
        logic        load;
        logic        mono;
        logic [15:0] width;
        logic [15:0] depth;
        logic        fwd;
        logic        hist_ok;
    } t_dp_ctrl;

endpackage

// ----- src/stereo_width_enhancer.sv -----
// Top level of the stereo width enhancer: handshakes, configuration, sequencer and delay line.
//
//  Channel   Dir  Handshake                 Payload
//  s stream  in   i_s_tvalid / o_s_tready   i_s_tdata: left_sample, right_sample
//  m stream  out  o_m_tvalid / i_m_tready   o_m_tdata: left_out, right_out
//  cfg       in   i_cfg_valid / o_cfg_ready i_cfg_addr, i_cfg_data
//
// One frame at a time: the transfer cycle plus 14 sequencer steps. The step sequence
// is set by the chain through the two shared 32x32 multipliers.
// Reset is synchronous and active low; it restores the registers to their defaults and
// clears the filter state. The delay line needs no clearing pass: a wrap flag marks
// entries never written, which read as zero.
// A stalled output holds the last step until the output register is free; the next
// frame is taken while a finished result still waits downstream.
module stereo_width_enhancer #(
    parameter int DELAY_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] left_sample, [31:16] right_sample
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [15:0] left_out, [31:16] right_out
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data
);

    localparam int AW = $clog2(DELAY_DEPTH);

    logic [15:0]   r_width, r_depth;
    logic          r_mono;
    logic [3:0]    r_state, n_state;
    logic [AW-1:0] r_wp, n_wp;
    logic          r_wrapped;
    logic          r_m_tvalid;
    logic [31:0]   r_m_tdata;

    logic [15:0]   w_width_c, w_depth_c;
    logic [19:0]   w_dep20;
    logic [4:0]    w_dly;
    logic [AW-1:0] w_dly_ext, w_raddr;
    logic [AW:0]   w_wrap_addr;
    logic          w_accept, w_out_free, w_wp_last;
    logic [15:0]   w_wdata, w_rdata;
    logic signed [15:0] w_left, w_right;
    swe_pkg::t_dp_ctrl  w_ctrl;

    // Configuration: always ready; written only between frames, kept by the user, not enforced by the block
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= swe_pkg::WIDTH_RESET;
            r_depth <= swe_pkg::DEPTH_RESET;
            r_mono  <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                swe_pkg::REG_WIDTH: r_width <= i_cfg_data;
                swe_pkg::REG_DEPTH: r_depth <= i_cfg_data;
                swe_pkg::REG_MONO:  r_mono  <= i_cfg_data[0];
                default:            r_mono  <= r_mono;
            endcase
        end
    end

    // Hold gains at full scale: width at 2.0, depth at 1.0
    assign w_width_c = (r_width > swe_pkg::GAIN_MAX) ? swe_pkg::GAIN_MAX : r_width;
    assign w_depth_c = (r_depth > swe_pkg::GAIN_MAX) ? swe_pkg::GAIN_MAX : r_depth;

    // Haas delay in frames: floor(depth * 20), 0 .. 20
    assign w_dep20   = 20'(w_depth_c) * 20'd20;
    assign w_dly     = w_dep20[19:15];
    assign w_dly_ext = AW'(w_dly);

    // Read address wraps back around the line when the pointer is below the delay
    assign w_wrap_addr = {1'b0, r_wp} + (AW+1)'(DELAY_DEPTH) - (AW+1)'(w_dly);
    assign w_raddr     = (r_wp >= w_dly_ext) ? (r_wp - w_dly_ext) : w_wrap_addr[AW-1:0];
    assign w_wp_last   = (r_wp == AW'(DELAY_DEPTH - 1));

    assign o_s_tready = (r_state == swe_pkg::ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_m_tvalid || i_m_tready;

    // Sequencer: walk the steps, hold the last one while the output is occupied
    always_comb begin
        n_state = r_state;
        case (r_state)
            swe_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = swe_pkg::ST_WID;
                end
            end
            swe_pkg::ST_OUT: begin
                if (w_out_free) begin
                    n_state = swe_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = r_state + 4'd1;
            end
        endcase
    end

    // Advance the write pointer once the side sample is stored
    assign n_wp = w_wp_last ? '0 : r_wp + AW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= swe_pkg::ST_IDLE;
            r_wp       <= '0;
            r_wrapped  <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == swe_pkg::ST_APF) begin
                r_wp <= n_wp;
                if (w_wp_last) begin
                    r_wrapped <= 1'b1;
                end
            end
            if (r_state == swe_pkg::ST_OUT && w_out_free) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == swe_pkg::ST_OUT && w_out_free) begin
            r_m_tdata <= {w_right, w_left};
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

    assign w_ctrl.step    = r_state;
    assign w_ctrl.load    = w_accept;
    assign w_ctrl.mono    = r_mono;
    assign w_ctrl.width   = w_width_c;
    assign w_ctrl.depth   = w_depth_c;
    // Zero delay reads the sample stored in the same frame
    assign w_ctrl.fwd     = (w_dly == 5'd0);
    // Entry behind the pointer holds a real sample only once written
    assign w_ctrl.hist_ok = r_wrapped || (r_wp >= w_dly_ext);

    swe_delay_ram #(
        .DEPTH (DELAY_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == swe_pkg::ST_APF),
        .i_waddr (r_wp),
        .i_wdata (w_wdata),
        .i_re    (r_state == swe_pkg::ST_WID),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    swe_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_left  ($signed(i_s_tdata[15:0])),
        .i_right ($signed(i_s_tdata[31:16])),
        .i_rdata (w_rdata),
        .o_wdata (w_wdata),
        .o_left  (w_left),
        .o_right (w_right)
    );

endmodule

// ----- src/swe_delay_ram.sv -----
// Side delay line storage: one write port, one registered read port.
module swe_delay_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [15:0]   o_rdata
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/swe_datapath.sv -----
// Fixed-point arithmetic of the enhancer: two shared multipliers stepped by the sequencer.
module swe_datapath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  swe_pkg::t_dp_ctrl      i_ctrl,
    input  logic signed [15:0]     i_left,
    input  logic signed [15:0]     i_right,
    input  logic        [15:0]     i_rdata,
    output logic        [15:0]     o_wdata,
    output logic signed [15:0]     o_left,
    output logic signed [15:0]     o_right
);

    // floor((v + half lsb) / 2^s)
    function automatic swe_pkg::t_prod f_rnd(input swe_pkg::t_prod v, input int unsigned s);
        swe_pkg::t_prod half;
        half = swe_pkg::t_prod'(1) <<< (s - 1);
        return (v + half) >>> s;
    endfunction

    function automatic swe_pkg::t_q420 f_sat24(input swe_pkg::t_prod v);
        swe_pkg::t_q420 res;
        if (v > swe_pkg::Q420_MAX) begin
            res = 24'sh7FFFFF;
        end else if (v < swe_pkg::Q420_MIN) begin
            res = -24'sh800000;
        end else begin
            res = 24'(v);
        end
        return res;
    endfunction

    function automatic swe_pkg::t_q420 f_clamp1(input swe_pkg::t_prod v);
        swe_pkg::t_q420 res;
        if (v > swe_pkg::ONE_Q420) begin
            res = 24'sd1048576;
        end else if (v < -swe_pkg::ONE_Q420) begin
            res = -24'sd1048576;
        end else begin
            res = 24'(v);
        end
        return res;
    endfunction

    // v * 32767 / 2^20, truncated toward zero
    function automatic logic signed [19:0] f_pcm(input swe_pkg::t_q420 v);
        logic signed [39:0] p;
        p = (40'(v) <<< 15) - 40'(v);
        if (p < 0) begin
            p = p + 40'sd1048575;
        end
        return p[39:20];
    endfunction

    logic signed [20:0] w_l, w_r;
    logic signed [21:0] w_sum, w_dif;
    logic signed [19:0] w_qpcm;
    logic signed [15:0] w_q;
    swe_pkg::t_op       op_a0, op_a1, op_b0, op_b1;
    swe_pkg::t_op       w_width, w_depth;

    logic signed [20:0] r_mid, r_sraw;
    swe_pkg::t_q420     r_side, r_rl7, r_rr7, r_apr, r_ap, r_d3, r_es, r_ol, r_or;
    logic signed [24:0] r_u;
    logic signed [15:0] r_dlyd;
    swe_pkg::t_op       r_dc;
    swe_pkg::t_prod     r_pa, r_pb, r_esp;
    swe_pkg::t_q420     r_allpass, r_revl, r_revr;

    assign w_l     = {i_left, 5'b0};
    assign w_r     = i_ctrl.mono ? w_l : {i_right, 5'b0};
    assign w_sum   = 22'(w_l) + 22'(w_r);
    assign w_dif   = 22'(w_l) - 22'(w_r);
    assign w_width = $signed({16'd0, i_ctrl.width});
    assign w_depth = $signed({16'd0, i_ctrl.depth});

    // Side sample as stored in the delay line, saturated to 16 bits
    assign w_qpcm = f_pcm(r_side);
    always_comb begin
        if (w_qpcm > 20'sd32767) begin
            w_q = 16'sh7FFF;
        end else if (w_qpcm < -20'sd32768) begin
            w_q = -16'sh8000;
        end else begin
            w_q = 16'(w_qpcm);
        end
    end
    assign o_wdata = w_q;

    // Operand selection for both multipliers
    always_comb begin
        op_a0 = '0;
        op_a1 = '0;
        op_b0 = '0;
        op_b1 = '0;
        case (i_ctrl.step)
            swe_pkg::ST_WID: begin
                op_a0 = 32'(r_sraw);
                op_a1 = w_width;
                op_b0 = w_depth;
                op_b1 = swe_pkg::C_0P3;
            end
            swe_pkg::ST_REV: begin
                op_a0 = 32'(r_revl);
                op_a1 = swe_pkg::C_0P7;
                op_b0 = 32'(r_revr);
                op_b1 = swe_pkg::C_0P7;
            end
            swe_pkg::ST_APF: begin
                op_a0 = 32'(r_side);
                op_a1 = swe_pkg::C_0P7;
                op_b0 = 32'(r_side);
                op_b1 = swe_pkg::UNITY_Q15 - w_depth;
            end
            swe_pkg::ST_DLY: begin
                op_a0 = 32'(r_dlyd) <<< 5;
                op_a1 = swe_pkg::C_0P3;
            end
            swe_pkg::ST_SUM: begin
                op_a0 = 32'(r_ap);
                op_a1 = swe_pkg::C_0P7;
            end
            swe_pkg::ST_FB: begin
                op_b0 = 32'(r_u);
                op_b1 = w_depth;
            end
            swe_pkg::ST_RVB: begin
                op_a0 = 32'(r_ol);
                op_a1 = r_dc;
                op_b0 = 32'(r_or);
                op_b1 = r_dc;
            end
            swe_pkg::ST_WET: begin
                op_a0 = 32'(r_revl);
                op_a1 = swe_pkg::C_0P15;
                op_b0 = 32'(r_revr);
                op_b1 = swe_pkg::C_0P15;
            end
            default: begin
                op_a0 = '0;
            end
        endcase
    end

    // Filter and reverb state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allpass <= '0;
            r_revl    <= '0;
            r_revr    <= '0;
        end else begin
            case (i_ctrl.step)
                swe_pkg::ST_FB: begin
                    r_allpass <= f_sat24(swe_pkg::t_prod'(r_side) - f_rnd(r_pa, 16));
                end
                swe_pkg::ST_RVU: begin
                    r_revl <= f_sat24(swe_pkg::t_prod'(r_rl7) + f_rnd(r_pa, 31));
                    r_revr <= f_sat24(swe_pkg::t_prod'(r_rr7) + f_rnd(r_pb, 31));
                end
                default: begin
                    r_revl <= r_revl;
                end
            endcase
        end
    end

    // Per-frame working values
    always_ff @(posedge i_clk) begin
        r_pa <= op_a0 * op_a1;
        r_pb <= op_b0 * op_b1;
        if (i_ctrl.load) begin
            r_mid  <= 21'(w_sum >>> 1);
            r_sraw <= 21'(w_dif >>> 1);
        end
        case (i_ctrl.step)
            swe_pkg::ST_REV: begin
                r_side <= f_sat24(f_rnd(r_pa, 14));
                r_dc   <= $signed(r_pb[31:0]);
            end
            swe_pkg::ST_APF: begin
                r_rl7 <= 24'(f_rnd(r_pa, 16));
                r_rr7 <= 24'(f_rnd(r_pb, 16));
                if (i_ctrl.fwd) begin
                    r_dlyd <= w_q;
                end else if (i_ctrl.hist_ok) begin
                    r_dlyd <= $signed(i_rdata);
                end else begin
                    r_dlyd <= '0;
                end
            end
            swe_pkg::ST_DLY: begin
                r_apr <= 24'(f_rnd(r_pa, 16));
                r_esp <= r_pb;
            end
            swe_pkg::ST_APS: begin
                r_ap <= f_sat24(swe_pkg::t_prod'(r_apr) + swe_pkg::t_prod'(r_allpass));
                r_d3 <= 24'(f_rnd(r_pa, 16));
            end
            swe_pkg::ST_SUM: begin
                r_u <= 25'(r_ap) + 25'(r_d3);
            end
            swe_pkg::ST_MIX: begin
                r_es <= f_sat24(f_rnd(r_esp + r_pb, 15));
            end
            swe_pkg::ST_LR: begin
                r_ol <= f_sat24(swe_pkg::t_prod'(r_mid) + swe_pkg::t_prod'(r_es));
                r_or <= f_sat24(swe_pkg::t_prod'(r_mid) - swe_pkg::t_prod'(r_es));
            end
            swe_pkg::ST_CLP: begin
                r_ol <= f_clamp1(swe_pkg::t_prod'(r_ol) + f_rnd(r_pa, 16));
                r_or <= f_clamp1(swe_pkg::t_prod'(r_or) + f_rnd(r_pb, 16));
            end
            default: begin
                r_u <= r_u;
            end
        endcase
    end

    assign o_left  = 16'(f_pcm(r_ol));
    assign o_right = 16'(f_pcm(r_or));

endmodule

// ----- test/swe_output_checker.sv -----
// Output checker of the stereo width enhancer: tracks the registers, predicts and compares frames.
module swe_output_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] left_sample, [31:16] right_sample
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // [15:0] left_out, [31:16] right_out
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic signed [15:0] right;
        logic signed [15:0] left;
    } t_stereo_frame;

    localparam int     LINE_DEPTH = 32;
    localparam longint Q_MAX      = 64'sd8388607;
    localparam longint Q_MIN      = -64'sd8388608;
    localparam longint UNITY      = 64'sd1048576;
    localparam longint K_0P7      = 64'sd45875;
    localparam longint K_0P3      = 64'sd19661;
    localparam longint K_0P15     = 64'sd9830;
    localparam longint FULL_GAIN  = 64'sd32768;

    logic [15:0]        width_reg;
    logic [15:0]        depth_reg;
    logic               mono_reg;
    logic signed [15:0] side_line [0:LINE_DEPTH-1];
    logic [4:0]         line_wr;
    logic signed [23:0] allpass_state;
    logic signed [23:0] echo_left;
    logic signed [23:0] echo_right;

    t_stereo_frame      frames_expected [$];
    t_stereo_frame      want;
    t_stereo_frame      got;

    function automatic longint clip24(input longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    // Round half up, then drop s fraction bits
    function automatic longint round_q(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // Scale Q4.20 to PCM, truncating toward zero
    function automatic longint to_pcm(input longint v);
        longint p;
        p = v * 32767;
        if (p >= 0) return p >>> 20;
        return -((-p) >>> 20);
    endfunction

    function automatic t_stereo_frame widen_frame(input logic [15:0] ls, input logic [15:0] rs);
        longint        w, dep, l, r, mid, side, ap, q, late, es, ol, orr;
        int            lag, rd;
        t_stereo_frame res;
        w   = (width_reg > 16'd32768) ? FULL_GAIN : longint'(width_reg);
        dep = (depth_reg > 16'd32768) ? FULL_GAIN : longint'(depth_reg);
        lag = int'((dep * 20) >>> 15);

        l = longint'($signed(ls)) * 32;
        r = mono_reg ? l : longint'($signed(rs)) * 32;
        mid  = (l + r) >>> 1;
        side = (l - r) >>> 1;
        side = clip24(round_q(side * w, 14));

        // first-order all-pass
        ap = clip24(round_q(side * K_0P7, 16) + longint'(allpass_state));
        allpass_state = 24'(clip24(side - round_q(ap * K_0P7, 16)));

        // store first, then read: a zero lag returns the sample just written
        q = to_pcm(side);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        side_line[line_wr] = 16'(q);
        rd = (int'(line_wr) + LINE_DEPTH - (lag % LINE_DEPTH)) % LINE_DEPTH;
        late = longint'(side_line[rd]) * 32;
        line_wr = line_wr + 5'd1;

        es = clip24(round_q(side * (FULL_GAIN - dep)
                            + (ap + round_q(late * K_0P3, 16)) * dep, 15));
        ol  = clip24(mid + es);
        orr = clip24(mid - es);

        echo_left  = 24'(clip24(round_q(longint'(echo_left) * K_0P7, 16)
                                + round_q(ol * K_0P3 * dep, 31)));
        echo_right = 24'(clip24(round_q(longint'(echo_right) * K_0P7, 16)
                                + round_q(orr * K_0P3 * dep, 31)));
        ol  = clip24(ol + round_q(longint'(echo_left) * K_0P15, 16));
        orr = clip24(orr + round_q(longint'(echo_right) * K_0P15, 16));

        if (ol > UNITY) ol = UNITY;
        if (ol < -UNITY) ol = -UNITY;
        if (orr > UNITY) orr = UNITY;
        if (orr < -UNITY) orr = -UNITY;
        res.left  = 16'(to_pcm(ol));
        res.right = 16'(to_pcm(orr));
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg     = 16'd16384;
            depth_reg     = 16'd16384;
            mono_reg      = 1'b1;
            line_wr       = '0;
            allpass_state = '0;
            echo_left     = '0;
            echo_right    = '0;
            for (int k = 0; k < LINE_DEPTH; k++) side_line[k] = '0;
            frames_expected.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_addr)
                    swe_pkg::REG_WIDTH: width_reg = i_cfg_data;
                    swe_pkg::REG_DEPTH: depth_reg = i_cfg_data;
                    swe_pkg::REG_MONO:  mono_reg  = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (frames_expected.size() == 0) begin
                    o_errors++;
                    $display("%0t: output transfer %h with no frame expected", $time, got);
                end else begin
                    want = frames_expected.pop_front();
                    if (got.left !== want.left) begin
                        o_errors++;
                        $display("%0t: left_out expected %0d got %0d",
                                 $time, want.left, got.left);
                    end
                    if (got.right !== want.right) begin
                        o_errors++;
                        $display("%0t: right_out expected %0d got %0d",
                                 $time, want.right, got.right);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                frames_expected.push_back(widen_frame(i_s_tdata[15:0], i_s_tdata[31:16]));
        end
        o_pending <= frames_expected.size();
    end

endmodule

// ----- test/stereo_width_enhancer_test.sv -----
// Stimulus and verdict for the stereo width enhancer, with the output checker beside the block.
module stereo_width_enhancer_test;

    // Index 3 is unmapped; a write there must leave every register alone
    localparam logic [1:0] REG_SPARE     = 2'd3;
    localparam int         LONG_HOLD     = 400;
    localparam int         SETTLE_CYC    = 24;
    localparam int         RANDOM_PHASES = 12;
    localparam int         PHASE_FRAMES  = 96;

    // Every input of the block starts from a known value
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;     // [15:0] left_sample, [31:16] right_sample
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;            // [15:0] left_out, [31:16] right_out
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_addr  = '0;
    logic [15:0] cfg_data  = '0;

    int check_errors;
    int frames_due;

    // steady: neither side idles; hold_output: the sink backs off for a long stretch
    bit steady      = 1'b0;
    bit hold_output = 1'b0;

    stereo_width_enhancer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_data  (cfg_data)
    );

    swe_output_checker checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_data  (cfg_data),
        .o_errors    (check_errors),
        .o_pending   (frames_due)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // Hard stop: well beyond the slowest legal run
    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Output sink: draw a back-off per frame, then hold tready until a transfer lands
    initial begin : sink
        int gap;
        bit held;
        held = 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_output && !held) begin
                gap  = LONG_HOLD;
                held = 1'b1;
            end else if (steady) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 6);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Offer one frame after a random gap (none when steady); tvalid stays high on return, so the
    // caller must either offer again or drop it within the same time step
    task automatic offer_frame(input logic [15:0] left, input logic [15:0] right);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {right, left};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
    endtask

    // Drop the input, wait for every predicted frame, then let the sequencer go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (frames_due != 0);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_addr  <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Keep cfg_valid high across the three writes, drop it after the last
    task automatic program_regs(input logic [15:0] width, input logic [15:0] depth,
                                input logic [15:0] mono_word);
        write_reg(swe_pkg::REG_WIDTH, width);
        write_reg(swe_pkg::REG_DEPTH, depth);
        write_reg(swe_pkg::REG_MONO, mono_word);
        cfg_valid <= 1'b0;
    endtask

    // Gain or depth setting: the extremes, above range, the zero-lag band, or anything in range
    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return swe_pkg::GAIN_MAX;
            2:       return 16'($urandom_range(32769, 65535));
            3:       return 16'($urandom_range(0, 1638));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic logic [15:0] pick_corner();
        case ($urandom_range(0, 3))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    initial begin : stimulus
        logic [15:0] left, right;
        int          mode;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings, mono: right field is ignored
        offer_frame(16'h7FFF, 16'($urandom));
        offer_frame(16'h8000, 16'($urandom));
        offer_frame(16'h0000, 16'hFFFF);
        settle();

        // Full width and depth, stereo: side saturates the delay store, outputs clamp
        program_regs(swe_pkg::GAIN_MAX, swe_pkg::GAIN_MAX, 16'h0000);
        offer_frame(16'h7FFF, 16'h8000);
        offer_frame(16'h8000, 16'h7FFF);
        offer_frame(16'h7FFF, 16'h7FFF);
        offer_frame(16'h8000, 16'h8000);
        offer_frame(16'h0000, 16'hFFFF);
        settle();

        // Width and depth above range act as their ceilings; stray mono bits ignored
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFE);
        offer_frame(16'h7FFF, 16'h8000);
        offer_frame(16'h8000, 16'h7FFF);
        offer_frame(16'h3039, 16'hCFC7);
        settle();

        // No side at all, no effect, zero lag
        program_regs(16'd0, 16'd0, 16'h0000);
        offer_frame(16'h7FFF, 16'h8000);
        offer_frame(16'hFFFF, 16'h0001);
        offer_frame(16'h03E8, 16'hF448);
        settle();

        // Zero lag with a real mix: the delay read sees the sample just stored
        program_regs(16'd20000, 16'd1000, 16'h0000);
        offer_frame(16'h7FFF, 16'h8000);
        offer_frame(16'h7FFF, 16'h8000);
        offer_frame(16'h8000, 16'h7FFF);
        offer_frame(16'h8000, 16'h7FFF);
        settle();

        // Unmapped index, then a one-frame lag back in mono
        write_reg(REG_SPARE, 16'hFFFF);
        program_regs(16'd16384, 16'd1639, 16'hAAAB);
        offer_frame(16'h7FFF, 16'h1234);
        offer_frame(16'h8000, 16'h5555);
        offer_frame(16'h0001, 16'hFFFF);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            case (p)
                0:       program_regs(swe_pkg::GAIN_MAX, swe_pkg::GAIN_MAX, 16'h0000);
                1:       program_regs(16'd0, 16'd0, 16'h0001);
                default: program_regs(pick_gain(), pick_gain(),
                                      {15'($urandom), 1'($urandom_range(0, 1))});
            endcase
            steady = (p % 4 == 1);
            for (int n = 0; n < PHASE_FRAMES; n++) begin
                // Back the sink off while frames keep coming, so the input stalls
                if (p == 2 && n == 10) begin
                    hold_output = 1'b1;
                    steady      = 1'b1;
                end
                if (p == 2 && n == 50)
                    steady = 1'b0;
                // Pause the source mid-phase until the pipeline is empty
                if (p == 3 && n == 48)
                    settle();
                mode = $urandom_range(0, 9);
                case (mode)
                    0: begin
                        left  = pick_corner();
                        right = pick_corner();
                    end
                    5, 6, 7: begin
                        left  = 16'($urandom_range(0, 4095) - 2048);
                        right = 16'($urandom_range(0, 4095) - 2048);
                    end
                    8: begin
                        left  = 16'($urandom);
                        right = left;
                    end
                    9: begin
                        left  = 16'($urandom);
                        right = -left;
                    end
                    default: begin
                        left  = 16'($urandom);
                        right = 16'($urandom);
                    end
                endcase
                offer_frame(left, right);
            end
        end
        settle();

        if (check_errors == 0 && frames_due == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
